### rtl/sign_vector_quadratic_max_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for sign_vector_quadratic_max
// Short forms of the concurrent checks used at the top level.
// ---------------------------------------------------------------------------
`ifndef SIGN_VECTOR_QUADRATIC_MAX_MACROS_SVH
`define SIGN_VECTOR_QUADRATIC_MAX_MACROS_SVH

// expr must hold at every edge outside reset
`define SVQM_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication
`define SVQM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SVQM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/svqm_pkg.sv
// ---------------------------------------------------------------------------
// svqm_pkg
// Types, widths and helpers shared by the sign vector search cells and control.
// ---------------------------------------------------------------------------
package svqm_pkg;

   localparam int MAX_VERTICES  = 16;
   localparam int PACK_VERTICES = 16;
   localparam int EDGE_BITS     = PACK_VERTICES * (PACK_VERTICES - 1) / 2;
   localparam int EDGE_IDX_W    = $clog2(EDGE_BITS);
   localparam int T_W           = 5;   // row sum, signed
   localparam int S_W           = 8;   // pair sum, signed
   localparam int R_W           = 7;   // result
   localparam int K_W           = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W         = $clog2(MAX_VERTICES);
   localparam int CNT_W         = $clog2(2 * MAX_VERTICES);
   localparam int MAX_RESULT    = EDGE_BITS;

   typedef logic [MAX_VERTICES-1:0] vmask_type;
   typedef logic signed [T_W-1:0]   tsum_type;
   typedef logic signed [S_W-1:0]   psum_type;
   typedef logic [R_W-1:0]          result_type;
   typedef logic [EDGE_BITS-1:0]    edges_type;

   localparam vmask_type ONE_MASK = vmask_type'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_STEP,
      ST_FINAL
   } state_type;

   // broadcast from control to the row of cells
   typedef struct packed {
      logic      load;
      logic      init;
      logic      step;
      vmask_type sel_mask;  // column during init, flip vertex during steps
   } ctl_type;

   // per-cell view of the broadcast
   typedef struct packed {
      logic      load;
      logic      init;
      logic      step;
      vmask_type sel_mask;
      logic      self_hit;
      logic      above_hit;
      logic      xf;
   } cell_ctl_type;

   // passed from cell to cell
   typedef struct packed {
      psum_type psum;    // systolic pair sum
      logic     pick_x;  // sign of selected vertex
      tsum_type pick_t;  // signed row sum of selected vertex
   } link_type;

   // row of the signing for one vertex; bit j set means -1
   function automatic vmask_type row_bits(input edges_type edges, input int unsigned row);
      vmask_type   bits;
      int unsigned a;
      int unsigned b;
      int unsigned e;
      bits = '0;
      for (int unsigned j = 0; j < MAX_VERTICES; j++) begin
         a = (row < j) ? row : j;
         b = (row < j) ? j : row;
         e = a * PACK_VERTICES - ((a * (a + 1)) >> 1) + (b - a - 1);
         if (j != row) begin
            bits[j] = edges[EDGE_IDX_W'(e)];
         end
      end
      return bits;
   endfunction

   function automatic result_type abs_sum(input psum_type v);
      logic [S_W-1:0] m;
      m = (v < 0) ? S_W'(-v) : S_W'(v);
      return m[R_W-1:0];
   endfunction

endpackage

### rtl/svqm_cell.sv
// ---------------------------------------------------------------------------
// svqm_cell
// One vertex: its signing row, sign, row sum and a stage of the pair-sum chain.
// ---------------------------------------------------------------------------
module svqm_cell (
   input  logic                  clock,
   input  svqm_pkg::cell_ctl_type ctl,
   input  svqm_pkg::vmask_type   row_load,
   input  svqm_pkg::link_type    link_in,
   output svqm_pkg::link_type    link_out
);

   svqm_pkg::vmask_type row_ff, row_in;
   logic                x_ff, x_in;
   svqm_pkg::tsum_type  t_ff, t_in;
   svqm_pkg::psum_type  p_ff, p_in;
   logic                a_bit;
   svqm_pkg::tsum_type  own_t;

   assign a_bit = |(row_ff & ctl.sel_mask);
   assign own_t = x_ff ? t_ff : -t_ff;

   always_comb begin
      row_in = row_ff;
      x_in   = x_ff;
      t_in   = t_ff;
      p_in   = p_ff;
      if (ctl.load) begin
         row_in = row_load;
         x_in   = 1'b1;
         t_in   = '0;
         p_in   = '0;
      end else if (ctl.init) begin
         if ((|ctl.sel_mask) && !ctl.self_hit) begin
            t_in = a_bit ? t_ff - svqm_pkg::tsum_type'(1) : t_ff + svqm_pkg::tsum_type'(1);
         end
         // pair term only from columns above this row
         if (ctl.above_hit) begin
            p_in = a_bit ? link_in.psum - svqm_pkg::psum_type'(1)
                         : link_in.psum + svqm_pkg::psum_type'(1);
         end else begin
            p_in = link_in.psum;
         end
      end else if (ctl.step) begin
         if (ctl.self_hit) begin
            x_in = ~x_ff;
         end else begin
            // t -= 2 * x_f * A
            t_in = (ctl.xf ^ a_bit) ? t_ff - svqm_pkg::tsum_type'(2)
                                    : t_ff + svqm_pkg::tsum_type'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      x_ff   <= x_in;
      t_ff   <= t_in;
      p_ff   <= p_in;
   end

   assign link_out.psum   = p_ff;
   assign link_out.pick_x = ctl.self_hit ? x_ff : link_in.pick_x;
   assign link_out.pick_t = ctl.self_hit ? own_t : link_in.pick_t;

endmodule

### rtl/svqm_ctrl.sv
// ---------------------------------------------------------------------------
// svqm_ctrl
// Sequencer: init sweep, Gray-code stepping, pair sum, best value and result.
// ---------------------------------------------------------------------------
module svqm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [4:0]              req_vertex_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output svqm_pkg::result_type    rsp_max_abs_sum,
   input  svqm_pkg::link_type      link_end,
   output svqm_pkg::ctl_type       ctl
);

   localparam logic [svqm_pkg::CNT_W-1:0] CNT_LAST = svqm_pkg::CNT_W'(2 * svqm_pkg::MAX_VERTICES - 1);
   localparam logic [svqm_pkg::CNT_W-1:0] CNT_COLS = svqm_pkg::CNT_W'(svqm_pkg::MAX_VERTICES);

   svqm_pkg::state_type           state_ff, state_in;
   logic [svqm_pkg::K_W-1:0]      k_ff, k_in, k_clamp;
   logic [svqm_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   svqm_pkg::vmask_type           c_ff, c_in;
   svqm_pkg::psum_type            s_ff, s_in;
   svqm_pkg::result_type          best_ff, best_in, best_now, s_abs;
   logic                          rsp_valid_ff, rsp_valid_in;
   svqm_pkg::result_type          rsp_data_ff, rsp_data_in;
   svqm_pkg::vmask_type           steps;
   svqm_pkg::vmask_type           flip_mask;

   always_comb begin
      if (req_vertex_count == 5'd0) begin
         k_clamp = svqm_pkg::K_W'(1);
      end else if (req_vertex_count > 5'(svqm_pkg::MAX_VERTICES)) begin
         k_clamp = svqm_pkg::K_W'(svqm_pkg::MAX_VERTICES);
      end else begin
         k_clamp = svqm_pkg::K_W'(req_vertex_count);
      end
   end

   assign steps     = svqm_pkg::ONE_MASK << (k_ff - svqm_pkg::K_W'(1));
   // lowest set bit of the step count, moved up one: vertex 0 stays fixed
   assign flip_mask = (c_ff & (~c_ff + svqm_pkg::ONE_MASK)) << 1;
   assign s_abs     = svqm_pkg::abs_sum(s_ff);
   assign best_now  = (s_abs > best_ff) ? s_abs : best_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      c_in         = c_ff;
      s_in         = s_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      req_stall    = 1'b1;
      ctl          = '0;
      case (state_ff)
         svqm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load = 1'b1;
               k_in     = k_clamp;
               cnt_in   = '0;
               c_in     = svqm_pkg::ONE_MASK;
               s_in     = '0;
               best_in  = '0;
               state_in = svqm_pkg::ST_INIT;
            end
         end
         svqm_pkg::ST_INIT: begin
            ctl.init = 1'b1;
            if (cnt_ff < CNT_COLS && cnt_ff < svqm_pkg::CNT_W'(k_ff)) begin
               ctl.sel_mask = svqm_pkg::ONE_MASK << cnt_ff[svqm_pkg::IDX_W-1:0];
            end
            // chain output drains into the pair sum
            s_in   = s_ff + link_end.psum;
            cnt_in = cnt_ff + svqm_pkg::CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = svqm_pkg::ST_STEP;
            end
         end
         svqm_pkg::ST_STEP: begin
            best_in = best_now;
            if (c_ff == steps) begin
               state_in = svqm_pkg::ST_FINAL;
            end else begin
               ctl.step     = 1'b1;
               ctl.sel_mask = flip_mask;
               s_in         = s_ff - (svqm_pkg::psum_type'(link_end.pick_t) <<< 1);
               c_in         = c_ff + svqm_pkg::ONE_MASK;
            end
         end
         svqm_pkg::ST_FINAL: begin
            best_in = best_now;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_now;
               state_in     = svqm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = svqm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svqm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_max_abs_sum = rsp_data_ff;

endmodule

### rtl/sign_vector_quadratic_max.sv
// From the request beat to the result beat the sequencer runs a load, the init
// sweep, the Gray-code stepping and a final state that waits for the response slot.
// One beat at a time: the Gray-code walk flips one vertex per cycle across the
// cell row, and a new request is taken only after the last result is registered.
// Synchronous active-high reset idles the sequencer and drops rsp_valid.
// ---------------------------------------------------------------------------
// sign_vector_quadratic_max
// Exhaustive largest |pair sum| over all sign vectors with vertex 0 fixed,
// on a row of vertex cells driven by a Gray-code sequencer.
// ---------------------------------------------------------------------------
`include "sign_vector_quadratic_max_macros.svh"

module sign_vector_quadratic_max (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_vertex_count,
   input  logic [63:0]          req_edge_signs_low,
   input  logic [55:0]          req_edge_signs_high,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [6:0]           rsp_max_abs_sum
);

   localparam int N = svqm_pkg::MAX_VERTICES;

   svqm_pkg::ctl_type      ctl;
   svqm_pkg::link_type     chain [N+1];
   svqm_pkg::cell_ctl_type cell_ctl [N];
   svqm_pkg::edges_type    edges;

   assign edges    = {req_edge_signs_high, req_edge_signs_low};
   assign chain[0] = '0;

   svqm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_count (req_vertex_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_abs_sum  (rsp_max_abs_sum),
      .link_end         (chain[N]),
      .ctl              (ctl)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      // columns strictly above this row
      localparam svqm_pkg::vmask_type ABOVE = ~({N{1'b1}} >> (N - 1 - i));

      assign cell_ctl[i] = '{
         load:      ctl.load,
         init:      ctl.init,
         step:      ctl.step,
         sel_mask:  ctl.sel_mask,
         self_hit:  ctl.sel_mask[i],
         above_hit: |(ctl.sel_mask & ABOVE),
         xf:        chain[N].pick_x
      };

      svqm_cell u_cell (
         .clock    (clock),
         .ctl      (cell_ctl[i]),
         .row_load (svqm_pkg::row_bits(edges, i)),
         .link_in  (chain[i]),
         .link_out (chain[i+1])
      );
   end

   `SVQM_ASSERT_ALWAYS(a_sel_onehot0, clock, reset, $onehot0(ctl.sel_mask), "select mask not one-hot")
   `SVQM_ASSERT_IMPL(a_step_flip, clock, reset, ctl.step, $onehot(ctl.sel_mask) && !ctl.sel_mask[0], "bad flip vertex")
   `SVQM_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")
   `SVQM_ASSERT_IMPL(a_rsp_range, clock, reset, rsp_valid, rsp_max_abs_sum <= 7'(svqm_pkg::MAX_RESULT), "result out of range")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for sign_vector_quadratic_max
// Drives signings through the request channel and compares every result
// beat with an independent Gray-code walk of the same pair sum.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;

   logic        clock;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_stall;
   logic [4:0]  req_vertex_count    = '0;
   logic [63:0] req_edge_signs_low  = '0;
   logic [55:0] req_edge_signs_high = '0;
   logic        rsp_valid;
   logic        rsp_stall           = 1'b0;
   logic [6:0]  rsp_max_abs_sum;

   // expected maxima, oldest first
   class pair_sum_board;
      svqm_pkg::result_type expected_max_q[$];
      int                   errors;

      function int edge_sign(svqm_pkg::edges_type edges, int i, int j);
         int a;
         int b;
         int e;
         if (i == j) return 0;
         a = (i < j) ? i : j;
         b = (i < j) ? j : i;
         e = a * svqm_pkg::PACK_VERTICES - (a * (a + 1)) / 2 + (b - a - 1);
         return edges[e] ? -1 : 1;
      endfunction

      // flips one vertex per step, vertex 0 held at plus
      function svqm_pkg::result_type max_abs_pair_sum(logic [4:0] count, logic [63:0] lo,
                                                      logic [55:0] hi);
         svqm_pkg::edges_type edges;
         svqm_pkg::vmask_type signs;
         int                  rows[svqm_pkg::MAX_VERTICES];
         int                  k;
         int                  total;
         int                  s;
         int                  best;
         int                  f;
         int                  xf;
         int                  steps;
         edges = {hi, lo};
         k     = count;
         if (k == 0) k = 1;
         if (k > svqm_pkg::MAX_VERTICES) k = svqm_pkg::MAX_VERTICES;
         signs = '1;
         total = 0;
         for (int i = 0; i < svqm_pkg::MAX_VERTICES; i++) rows[i] = 0;
         for (int i = 0; i < k; i++) begin
            for (int j = 0; j < k; j++) rows[i] += edge_sign(edges, i, j);
            total += rows[i];
         end
         s     = total / 2;
         best  = (s < 0) ? -s : s;
         steps = 1 << (k - 1);
         for (int c = 1; c < steps; c++) begin
            f = 1;
            while (((c >> (f - 1)) & 1) == 0) f++;
            xf       = signs[f] ? 1 : -1;
            s       -= 2 * xf * rows[f];
            signs[f] = ~signs[f];
            for (int j = 0; j < k; j++)
               if (j != f) rows[j] -= 2 * xf * edge_sign(edges, j, f);
            if (((s < 0) ? -s : s) > best) best = (s < 0) ? -s : s;
         end
         return svqm_pkg::result_type'(best);
      endfunction

      function void note_request(logic [4:0] count, logic [63:0] lo, logic [55:0] hi);
         expected_max_q.push_back(max_abs_pair_sum(count, lo, hi));
      endfunction

      task report(string msg);
         $display("%t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(svqm_pkg::result_type got);
         svqm_pkg::result_type want;
         if (expected_max_q.size() == 0) begin
            report($sformatf("result %0d with nothing outstanding", got));
         end else begin
            want = expected_max_q.pop_front();
            if (got !== want)
               report($sformatf("max_abs_sum %0d, expected %0d", got, want));
         end
      endtask
   endclass

   pair_sum_board board = new();
   bit            calm;       // stretch with no idling on either side
   int            big_left;   // cap on slow full-size walks in the random part

   sign_vector_quadratic_max u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_vertex_count    (req_vertex_count),
      .req_edge_signs_low  (req_edge_signs_low),
      .req_edge_signs_high (req_edge_signs_high),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_max_abs_sum     (rsp_max_abs_sum)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 200);
   endfunction

   // mostly small walks, a few mid-sized, rarely the full 16 vertices
   function automatic logic [4:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3 && big_left > 0) begin
         big_left--;
         return 5'($urandom_range(16, 31));
      end
      if (r < 15) return 5'($urandom_range(11, 14));
      return 5'($urandom_range(0, 10));
   endfunction

   function automatic logic [63:0] pick_edges();
      logic [63:0] a;
      logic [63:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return a & b;
         1: return a | b;
         default: return a;
      endcase
   endfunction

   task automatic send_item(input logic [4:0] count, input logic [63:0] lo,
                            input logic [55:0] hi);
      req_valid           <= 1'b1;
      req_vertex_count    <= count;
      req_edge_signs_low  <= lo;
      req_edge_signs_high <= hi;
      do @(posedge clock); while (req_stall);
      board.note_request(count, lo, hi);
   endtask

   task automatic sender_gap();
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (board.expected_max_q.size() != 0) @(posedge clock);
   endtask

   // result side: random stall runs, checked beat by beat
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_max_abs_sum);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      logic [63:0] ones;
      ones     = '1;
      big_left = 4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: count extremes, saturation, empty graph, frustrated triangle
      send_item(5'd0,  {$urandom, $urandom}, 56'({$urandom, $urandom})); sender_gap();
      send_item(5'd1,  ones, ones[55:0]);                                 sender_gap();
      send_item(5'd2,  64'h0, 56'h0);                                     sender_gap();
      send_item(5'd2,  64'h1, 56'h0);                                     sender_gap();
      send_item(5'd3,  64'h0, 56'h0);                                     sender_gap();
      send_item(5'd3,  ones, ones[55:0]);                                 sender_gap();
      send_item(5'd4,  {$urandom, $urandom}, 56'({$urandom, $urandom})); sender_gap();
      send_item(5'd5,  64'h5555_5555_5555_5555, 56'hAA_AAAA_AAAA_AAAA);   sender_gap();
      send_item(5'd8,  64'h0, 56'h0);                                     sender_gap();
      send_item(5'd8,  ones, ones[55:0]);                                 sender_gap();
      send_item(5'd12, 64'hAAAA_AAAA_AAAA_AAAA, 56'h55_5555_5555_5555);   sender_gap();
      send_item(5'd15, {$urandom, $urandom}, 56'({$urandom, $urandom})); sender_gap();
      send_item(5'd16, 64'h0, 56'h0);                                     sender_gap();
      send_item(5'd31, ones, ones[55:0]);                                 sender_gap();
      send_item(5'd16, ones, 56'h0);                                      sender_gap();

      for (int n = 0; n < 85; n++) begin
         if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == 50) begin
            // hold off until the pipe is empty
            req_valid <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         send_item(pick_count(), pick_edges(), 56'(pick_edges()));
         sender_gap();
      end
      req_valid <= 1'b0;
      calm      = 1'b0;

      wait_drained();
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
